FILE: hw/rtl/tap_pkg.sv
// Shared constants, register indexes and the posterize function for the
// tile average posterize block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tap_pkg;

    // Default limits, handed to the top level as parameter defaults.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MAX_TILE_DEF   = 64;

    // Fixed field widths.
    localparam int CFG_W      = 12;
    localparam int LEVEL_W    = 4;
    localparam int REG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int TILE_IDX_W = 11;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESOLUTION   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_LEVEL  = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0]   RESOLUTION_RST   = 12'd200;
    localparam logic [LEVEL_W-1:0] COLOR_LEVEL_RST  = 4'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 4'd8;
    localparam logic [PIX_W-1:0]   PIX_MAX          = 8'hFF;

    // Keep the top level bits of a channel and refill the rest by repeating them.
    function automatic logic [PIX_W-1:0] posterize(input logic [PIX_W-1:0] avg,
                                                   input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] step;
        logic [PIX_W-1:0]   mask;
        logic [PIX_W-1:0]   val;
        if (level == '0)
            return '0;
        lvl  = (level > LEVEL_MAX) ? LEVEL_MAX : level;
        mask = PIX_MAX << (LEVEL_MAX - lvl);
        val  = avg & mask;
        step = lvl;
        for (int i = 0; i < 3; i++)
        begin
            if (step < LEVEL_MAX)
            begin
                val  = val | (val >> step);
                step = step << 1;
            end
        end
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tap_ram #(
    parameter int DATA_W = 60,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tap_div.sv
// Restoring divider, one quotient bit per cycle, for the tile block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tap_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       valid,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  valid_reg, valid_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            cnt_next   = CNT_W'(DIVIDEND_W);
            valid_next = 1'b0;
            rem_next   = '0;
            dvs_next   = divisor;
            quo_next   = dividend;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign valid    = valid_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tile_average_posterize.sv
// Each pixel is accepted, then its column sum is read, updated and written back.
// A pixel that closes a tile also starts the 20-step averaging dividers; its result
// goes into the output register once they finish and that register is free. The
// next pixel is taken only after that load, once the sequencer is back in idle.
// After reset and after any configuration write, tile size and tile counts are
// worked out (three divider passes); no pixel is taken then. Reset (rst_n,
// asynchronous, active low) clears counters and control and loads the configuration
// registers with their reset values; column sums are undefined until the first
// pixel of each tile writes them. Depends on tap_pkg, tap_ram and tap_div.
`timescale 1ns / 1ps
`default_nettype none

module tile_average_posterize #(
    parameter int MAX_WIDTH  = tap_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tap_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_TILE   = tap_pkg::MAX_TILE_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Pixel input. tdata: red [7:0], green [15:8], blue [23:16].
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [tap_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: frame_start [0].
    input  wire logic                             s_axis_tuser,
    // Tile result. tdata: tile_column [10:0], tile_row [21:11], out_red [29:22],
    // out_green [37:30], out_blue [45:38], zero fill [47:46].
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [tap_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [tap_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [tap_pkg::CFG_W-1:0]        cfg_data
);

    import tap_pkg::*;

    localparam int PXW    = $clog2(MAX_WIDTH + 1);
    localparam int PYW    = $clog2(MAX_HEIGHT + 1);
    localparam int DIMW   = (PXW > PYW) ? PXW : PYW;
    localparam int SW     = $clog2(MAX_TILE + 1);
    localparam int AREA_W = 2 * SW;
    localparam int DVW    = (AREA_W > CFG_W) ? AREA_W : CFG_W;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CMPW   = ((DIMW > TILE_IDX_W) ? DIMW : TILE_IDX_W) + 1;
    localparam int RAM_W  = 3 * SUM_W;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CFG_SIDE = 6'b000010,
        ST_CFG_NTX  = 6'b000100,
        ST_CFG_NTY  = 6'b001000,
        ST_READ     = 6'b010000,
        ST_DIV      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers and derived tile geometry.
    logic [CFG_W-1:0]   width_reg, height_reg, res_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               dirty_reg, dirty_next, dirty_clr;
    logic [SW-1:0]      s_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [PXW-1:0]     ntx_reg;
    logic [PYW-1:0]     nty_reg;
    logic [PXW-1:0]     w_eff;
    logic [PYW-1:0]     h_eff;
    logic [CFG_W-1:0]   res_eff;
    logic [DIMW-1:0]    side;
    logic [SW-1:0]      tile_s_next;

    // Raster counters.
    logic [PXW-1:0]        pixel_x_reg, pixel_x_next, x_c;
    logic [PYW-1:0]        pixel_y_reg, pixel_y_next, y_c;
    logic [SW-1:0]         xi_reg, xi_next, xi_c;
    logic [SW-1:0]         yi_reg, yi_next, yi_c;
    logic [TILE_IDX_W-1:0] tile_x_reg, tile_x_next, tx_c;
    logic [TILE_IDX_W-1:0] tile_y_reg, tile_y_next, ty_c;
    logic                  x_wrap, y_wrap, xi_end, yi_end;

    // Pixel held between acceptance and the column sum update.
    logic [PIX_W-1:0]      px_reg [3];
    logic                  in_tile_reg, first_reg, last_reg;
    logic [TILE_IDX_W-1:0] col_reg, row_reg;

    // Memory and divider connections.
    logic             accept;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;
    logic [SUM_W-1:0] new_sum [3];
    logic             div_start, avg_start;
    logic [SUM_W-1:0] dividend0;
    logic [DVW-1:0]   divisor0;
    logic             div_valid [3];
    logic [SUM_W-1:0] div_quo [3];
    logic [PIX_W-1:0] avg_sat [3];

    // Output register.
    logic                  load_out;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Effective frame size, resolution and smaller side.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = PXW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = PXW'(MAX_WIDTH);
        else
            w_eff = PXW'(width_reg);
        if (height_reg == '0)
            h_eff = PYW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = PYW'(MAX_HEIGHT);
        else
            h_eff = PYW'(height_reg);
        res_eff = (res_reg == '0) ? CFG_W'(1) : res_reg;
        side    = (DIMW'(w_eff) < DIMW'(h_eff)) ? DIMW'(w_eff) : DIMW'(h_eff);
    end

    // Tile size from the first divider pass, clamped to one and the maximum.
    always_comb
    begin
        if (div_quo[0] == '0)
            tile_s_next = SW'(1);
        else if (div_quo[0] > SUM_W'(MAX_TILE))
            tile_s_next = SW'(MAX_TILE);
        else
            tile_s_next = SW'(div_quo[0]);
    end

    // Current position (frame start restarts it) and the next position.
    always_comb
    begin
        x_c  = s_axis_tuser ? '0 : pixel_x_reg;
        y_c  = s_axis_tuser ? '0 : pixel_y_reg;
        xi_c = s_axis_tuser ? '0 : xi_reg;
        yi_c = s_axis_tuser ? '0 : yi_reg;
        tx_c = s_axis_tuser ? '0 : tile_x_reg;
        ty_c = s_axis_tuser ? '0 : tile_y_reg;

        x_wrap = ((PXW + 1)'(x_c) + 1'b1) >= (PXW + 1)'(w_eff);
        y_wrap = ((PYW + 1)'(y_c) + 1'b1) >= (PYW + 1)'(h_eff);
        xi_end = ((SW + 1)'(xi_c) + 1'b1) >= (SW + 1)'(s_reg);
        yi_end = ((SW + 1)'(yi_c) + 1'b1) >= (SW + 1)'(s_reg);

        pixel_x_next = x_c;
        pixel_y_next = y_c;
        xi_next      = xi_c;
        yi_next      = yi_c;
        tile_x_next  = tx_c;
        tile_y_next  = ty_c;
        if (x_wrap)
        begin
            pixel_x_next = '0;
            xi_next      = '0;
            tile_x_next  = '0;
            if (y_wrap)
            begin
                pixel_y_next = '0;
                yi_next      = '0;
                tile_y_next  = '0;
            end
            else
            begin
                pixel_y_next = y_c + 1'b1;
                if (yi_end)
                begin
                    yi_next     = '0;
                    tile_y_next = ty_c + 1'b1;
                end
                else
                    yi_next = yi_c + 1'b1;
            end
        end
        else
        begin
            pixel_x_next = x_c + 1'b1;
            if (xi_end)
            begin
                xi_next     = '0;
                tile_x_next = tx_c + 1'b1;
            end
            else
                xi_next = xi_c + 1'b1;
        end
    end

    // Column sum update: the first pixel of a tile restarts the sums.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (first_reg)
                new_sum[c] = SUM_W'(px_reg[c]);
            else
                new_sum[c] = ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(px_reg[c]);
        end
        ram_wdata = {new_sum[2], new_sum[1], new_sum[0]};
        ram_waddr = AW'(col_reg);
        ram_re    = accept;
        ram_raddr = AW'(tx_c);
    end

    // Sequencer: geometry passes after configuration, then one pixel at a time.
    // A pixel's read and write of the column sums finish before the next is
    // accepted, so accesses to one entry never overlap.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        avg_start  = 1'b0;
        dividend0  = new_sum[0];
        divisor0   = DVW'(area_reg);
        dirty_clr  = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    div_start  = 1'b1;
                    dividend0  = SUM_W'(side);
                    divisor0   = DVW'(res_eff);
                    dirty_clr  = 1'b1;
                    state_next = ST_CFG_SIDE;
                end
                else if (accept)
                    state_next = ST_READ;
            end
            ST_CFG_SIDE:
            begin
                if (div_valid[0])
                begin
                    div_start  = 1'b1;
                    dividend0  = SUM_W'(w_eff);
                    divisor0   = DVW'(tile_s_next);
                    state_next = ST_CFG_NTX;
                end
            end
            ST_CFG_NTX:
            begin
                if (div_valid[0])
                begin
                    div_start  = 1'b1;
                    dividend0  = SUM_W'(h_eff);
                    divisor0   = DVW'(s_reg);
                    state_next = ST_CFG_NTY;
                end
            end
            ST_CFG_NTY:
            begin
                if (div_valid[0])
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                ram_we = in_tile_reg;
                if (in_tile_reg && last_reg)
                begin
                    div_start  = 1'b1;
                    avg_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_valid[0] && (!m_valid_reg || m_axis_tready))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !dirty_reg && !cfg_we;

    // Any write forces the geometry to be worked out again.
    always_comb
    begin
        if (cfg_we)
            dirty_next = 1'b1;
        else if (dirty_clr)
            dirty_next = 1'b0;
        else
            dirty_next = dirty_reg;
    end

    // Output handshake.
    always_comb
    begin
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    // Saturate averages to one channel's range.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (div_quo[c] > SUM_W'(PIX_MAX))
                avg_sat[c] = PIX_MAX;
            else
                avg_sat[c] = div_quo[c][PIX_W-1:0];
        end
    end

    // Control state, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dirty_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
            width_reg   <= FRAME_WIDTH_RST;
            height_reg  <= FRAME_HEIGHT_RST;
            res_reg     <= RESOLUTION_RST;
            level_reg   <= COLOR_LEVEL_RST;
            s_reg       <= SW'(1);
            area_reg    <= AREA_W'(1);
            ntx_reg     <= '0;
            nty_reg     <= '0;
            pixel_x_reg <= '0;
            pixel_y_reg <= '0;
            xi_reg      <= '0;
            yi_reg      <= '0;
            tile_x_reg  <= '0;
            tile_y_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    REG_RESOLUTION:   res_reg    <= cfg_data;
                    REG_COLOR_LEVEL:  level_reg  <= cfg_data[LEVEL_W-1:0];
                    default:          ;
                endcase
            end
            if (state_reg == ST_CFG_SIDE && div_valid[0])
                s_reg <= tile_s_next;
            if (state_reg == ST_CFG_NTX && div_valid[0])
            begin
                ntx_reg  <= PXW'(div_quo[0]);
                area_reg <= s_reg * s_reg;
            end
            if (state_reg == ST_CFG_NTY && div_valid[0])
                nty_reg <= PYW'(div_quo[0]);
            if (accept)
            begin
                pixel_x_reg <= pixel_x_next;
                pixel_y_reg <= pixel_y_next;
                xi_reg      <= xi_next;
                yi_reg      <= yi_next;
                tile_x_reg  <= tile_x_next;
                tile_y_reg  <= tile_y_next;
            end
        end
    end

    // Accepted pixel and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg[0]   <= s_axis_tdata[PIX_W-1:0];
            px_reg[1]   <= s_axis_tdata[2*PIX_W-1:PIX_W];
            px_reg[2]   <= s_axis_tdata[3*PIX_W-1:2*PIX_W];
            in_tile_reg <= (CMPW'(tx_c) < CMPW'(ntx_reg)) && (CMPW'(ty_c) < CMPW'(nty_reg));
            first_reg   <= (xi_c == '0) && (yi_c == '0);
            last_reg    <= xi_end && yi_end;
            col_reg     <= tx_c;
            row_reg     <= ty_c;
        end
        if (load_out)
        begin
            m_data_reg <= {2'b00,
                           posterize(avg_sat[2], level_reg),
                           posterize(avg_sat[1], level_reg),
                           posterize(avg_sat[0], level_reg),
                           row_reg, col_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Per-tile-column channel sums.
    tap_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Red divider also serves the tile geometry passes.
    tap_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DVW)
    ) u_div_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend0),
        .divisor  (divisor0),
        .valid    (div_valid[0]),
        .quotient (div_quo[0])
    );

    tap_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DVW)
    ) u_div_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (new_sum[1]),
        .divisor  (DVW'(area_reg)),
        .valid    (div_valid[1]),
        .quotient (div_quo[1])
    );

    tap_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DVW)
    ) u_div_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (new_sum[2]),
        .divisor  (DVW'(area_reg)),
        .valid    (div_valid[2]),
        .quotient (div_quo[2])
    );

    // An accepted pixel always goes on to its column sum update.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accepted pixel did not reach the sum update");

    // A sum is written back to the entry read for the same pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ($past(ram_re) && ram_waddr == $past(ram_raddr)))
        else $error("column sum written to a different entry than read");

    // Results appear only when averaging finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_DIV)
        else $error("result raised outside the averaging step");

    // Once geometry is settled the tile size is in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !dirty_reg) |-> (s_reg != '0 && 32'(s_reg) <= MAX_TILE))
        else $error("tile size out of range");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for tile_average_posterize: streams pixels, predicts
// each finished tile color and checks every result item field by field.
// Depends on tap_pkg and the tile_average_posterize RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_W         = tap_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H         = tap_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_S         = tap_pkg::MAX_TILE_DEF;
    localparam int IDLE_PCT      = 19;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 640;

    // Register image, as written through the configuration port.
    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
        logic [11:0] res;
        logic [3:0]  level;
    } regs_t;

    // Raster position and tile position inside the frame.
    typedef struct packed {
        logic [10:0] px;
        logic [10:0] py;
        logic [5:0]  xt;
        logic [5:0]  yt;
        logic [10:0] tx;
        logic [10:0] ty;
    } scan_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Same bit order as the result tdata, lowest field last.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [10:0] row;
        logic [10:0] col;
    } tile_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    // Predictor state: live follows accepted items, plan follows queued items.
    regs_t  settings;
    scan_t  live = '0;
    scan_t  plan = '0;
    logic [2:0][tap_pkg::SUM_W-1:0] col_sum [MAX_W];
    bit     col_seen [MAX_W];

    pixel_t pixel_queue [$];
    tile_t  tile_results [$];
    pixel_t on_bus;
    tile_t  got;
    tile_t  want;
    int     queued = 0;
    int     accepted = 0;
    int     mismatches = 0;
    bit     idle_on = 1'b1;
    bit     hold_req = 1'b0;
    bit     hold_taken = 1'b0;
    int     hold_left = 0;

    tile_average_posterize dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // A zero dimension counts as one, a large one saturates.
    function automatic int unsigned clamp_dim(input logic [11:0] v, input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic int unsigned tile_side(input regs_t r);
        int unsigned w;
        int unsigned h;
        int unsigned side;
        int unsigned div;
        int unsigned s;
        w    = clamp_dim(r.width, MAX_W);
        h    = clamp_dim(r.height, MAX_H);
        side = (w < h) ? w : h;
        div  = (r.res == 0) ? 1 : r.res;
        s    = side / div;
        if (s < 1)
            s = 1;
        if (s > MAX_S)
            s = MAX_S;
        return s;
    endfunction

    // True when the current position lies in a complete tile.
    function automatic bit in_full_tile(input regs_t r, input scan_t st);
        int unsigned s;
        s = tile_side(r);
        return (st.tx < clamp_dim(r.width, MAX_W) / s) &&
               (st.ty < clamp_dim(r.height, MAX_H) / s);
    endfunction

    // Move one pixel along the raster; counters wrap at the current limits.
    function automatic void step_scan(inout scan_t st, input regs_t r);
        int unsigned s;
        s = tile_side(r);
        if (st.px + 1 >= clamp_dim(r.width, MAX_W))
        begin
            st.px = '0;
            st.xt = '0;
            st.tx = '0;
            if (st.py + 1 >= clamp_dim(r.height, MAX_H))
            begin
                st.py = '0;
                st.yt = '0;
                st.ty = '0;
            end
            else
            begin
                st.py = st.py + 11'd1;
                if (st.yt + 1 >= s)
                begin
                    st.yt = '0;
                    st.ty = st.ty + 11'd1;
                end
                else
                    st.yt = st.yt + 6'd1;
            end
        end
        else
        begin
            st.px = st.px + 11'd1;
            if (st.xt + 1 >= s)
            begin
                st.xt = '0;
                st.tx = st.tx + 11'd1;
            end
            else
                st.xt = st.xt + 6'd1;
        end
    endfunction

    // Truncated average, top bits kept and the rest refilled by repetition.
    function automatic logic [7:0] quantize(input logic [19:0] sum, input int unsigned area,
                                            input logic [3:0] level);
        int unsigned avg;
        int unsigned kept;
        int unsigned shift;
        logic [7:0]  v;
        if (level == 0)
            return 8'd0;
        avg = sum / area;
        if (avg > 255)
            avg = 255;
        kept  = (level > 8) ? 8 : level;
        v     = 8'(avg) & 8'(8'hFF << (8 - kept));
        shift = kept;
        while (shift < 8)
        begin
            v     = v | (v >> shift);
            shift = shift * 2;
        end
        return v;
    endfunction

    // Accumulate one accepted pixel; returns 1 when it closes a tile.
    function automatic bit predict_tile(input pixel_t p, output tile_t t);
        int unsigned s;
        logic [7:0]  chan [3];
        bit          first;
        bit          done;
        s    = tile_side(settings);
        t    = '0;
        done = 1'b0;
        if (p.frame_start)
            live = '0;
        chan[0] = p.red;
        chan[1] = p.green;
        chan[2] = p.blue;
        if (in_full_tile(settings, live))
        begin
            first = (live.xt == 0) && (live.yt == 0);
            for (int c = 0; c < 3; c++)
                col_sum[live.tx][c] = first ? {12'd0, chan[c]}
                                            : col_sum[live.tx][c] + {12'd0, chan[c]};
            if (live.xt + 1 >= s && live.yt + 1 >= s)
            begin
                t.col   = live.tx;
                t.row   = live.ty;
                t.red   = quantize(col_sum[live.tx][0], s * s, settings.level);
                t.green = quantize(col_sum[live.tx][1], s * s, settings.level);
                t.blue  = quantize(col_sum[live.tx][2], s * s, settings.level);
                done    = 1'b1;
            end
        end
        step_scan(live, settings);
        return done;
    endfunction

    function automatic void check_field(input string field, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function automatic regs_t make_regs(input int unsigned w, input int unsigned h,
                                        input int unsigned res, input int unsigned lvl);
        regs_t r;
        r.width  = 12'(w);
        r.height = 12'(h);
        r.res    = 12'(res);
        r.level  = 4'(lvl);
        return r;
    endfunction

    // Channel values lean toward the extremes now and then.
    function automatic logic [7:0] channel_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return 8'h00;
        if (pick < 24)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [3:0] random_level();
        if ($urandom_range(99) < 15)
            return $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    // Queue a pixel. A pixel that would read a column sum never written
    // restarts the frame instead.
    task automatic queue_pixel(input logic fs, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        pixel_t p;
        p.frame_start = fs;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        if (!fs && in_full_tile(settings, plan) && !(plan.xt == 0 && plan.yt == 0) &&
            !col_seen[plan.tx])
            p.frame_start = 1'b1;
        if (p.frame_start)
            plan = '0;
        if (in_full_tile(settings, plan))
            col_seen[plan.tx] = 1'b1;
        step_scan(plan, settings);
        pixel_queue.push_back(p);
        queued++;
    endtask

    task automatic queue_random(input logic fs);
        queue_pixel(fs, channel_value(), channel_value(), channel_value());
    endtask

    // Wait until every item is taken and every tile result has come back.
    task automatic settle();
        while (accepted != queued || tile_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input logic [1:0] idx, input logic [11:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Write the selected registers back to back: width, height, resolution, level.
    task automatic program_regs(input regs_t r, input logic [3:0] which);
        if (which[0])
        begin
            write_one(tap_pkg::REG_FRAME_WIDTH, r.width);
            settings.width = r.width;
        end
        if (which[1])
        begin
            write_one(tap_pkg::REG_FRAME_HEIGHT, r.height);
            settings.height = r.height;
        end
        if (which[2])
        begin
            write_one(tap_pkg::REG_RESOLUTION, r.res);
            settings.res = r.res;
        end
        if (which[3])
        begin
            write_one(tap_pkg::REG_COLOR_LEVEL, {8'd0, r.level});
            settings.level = r.level;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pixel driver: predicts on each accepted item, then offers the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted++;
                if (predict_tile(on_bus, want))
                    tile_results.push_back(want);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pixel_queue.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT))
                begin
                    on_bus = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_bus.blue, on_bus.green, on_bus.red};
                    s_axis_tuser  <= on_bus.frame_start;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = tile_t'(m_axis_tdata[45:0]);
                if (tile_results.size() == 0)
                begin
                    $display("%0t ns: unexpected tile result, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = tile_results.pop_front();
                    check_field("tile_column", want.col, got.col);
                    check_field("tile_row", want.row, got.row);
                    check_field("out_red", want.red, got.red);
                    check_field("out_green", want.green, got.green);
                    check_field("out_blue", want.blue, got.blue);
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken    <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus: directed frames, the largest tile size, then random phases.
    initial
    begin
        regs_t cfg;
        int    phase;
        int    kind;
        int    n;
        int    frame;
        int    random_items;
        logic  lead_fs;
        settings = make_regs(tap_pkg::FRAME_WIDTH_RST, tap_pkg::FRAME_HEIGHT_RST,
                             tap_pkg::RESOLUTION_RST, tap_pkg::COLOR_LEVEL_RST);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the counters start at zero without a frame start.
        queue_random(1'b0);
        queue_random(1'b0);
        settle();

        // Two 2x2 tiles, one full white and one full black, all bits kept.
        program_regs(make_regs(4, 2, 1, 8), 4'hF);
        for (int i = 0; i < 8; i++)
            queue_pixel(i == 0, (i % 4 < 2) ? 8'hFF : 8'h00, (i % 4 < 2) ? 8'hFF : 8'h00,
                        (i % 4 < 2) ? 8'hFF : 8'h00);
        settle();

        // Zero width and resolution, oversized height, color level zero.
        program_regs(make_regs(0, 4095, 0, 0), 4'hF);
        for (int i = 0; i < 3; i++)
            queue_random(i == 0);
        settle();

        // Oversized width and resolution, level above eight; the last pixel restarts.
        program_regs(make_regs(4095, 3, 4095, 15), 4'hF);
        queue_pixel(1'b1, 8'h80, 8'h7F, 8'hA5);
        queue_pixel(1'b0, 8'h7F, 8'hA5, 8'h5A);
        queue_pixel(1'b0, 8'hA5, 8'h5A, 8'h80);
        queue_pixel(1'b1, 8'h5A, 8'h80, 8'h7F);
        settle();

        // Incomplete right edge tile is skipped; one bit per channel.
        program_regs(make_regs(3, 2, 1, 1), 4'hF);
        for (int i = 0; i < 6; i++)
            queue_random(i == 0);
        settle();

        // Tile size clamped to the largest tile: one tile width moves the column
        // index on, and a one pixel tile size afterwards shows where it stands.
        program_regs(make_regs(130, 65, 1, 8), 4'hF);
        for (int i = 0; i < 64; i++)
            queue_random(i == 0);
        settle();
        program_regs(make_regs(130, 65, 65, 8), 4'b0100);
        for (int i = 0; i < 4; i++)
            queue_random(1'b0);

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            idle_on = !(phase >= 2 && phase < 4);
            kind    = $urandom_range(99);
            cfg     = settings;
            lead_fs = 1'b0;
            n       = 0;
            if (phase == 3)
            begin
                // One result per pixel while the receiver holds off.
                program_regs(make_regs(16, 8, 16, 8), 4'hF);
                hold_req = 1'b1;
                lead_fs  = 1'b1;
                n        = 200;
            end
            else if (kind < 70)
            begin
                if ($urandom_range(99) < 8)
                begin
                    case ($urandom_range(3))
                        0: cfg.width = 12'd0;
                        1: cfg.width = 12'd1;
                        2: cfg.width = 12'd2048;
                        default: cfg.width = 12'd4095;
                    endcase
                    cfg.height = 12'($urandom_range(1, 4));
                    cfg.res    = $urandom_range(1) ? 12'd0 : 12'($urandom);
                end
                else
                begin
                    cfg.width  = 12'($urandom_range(1, 20));
                    cfg.height = 12'($urandom_range(1, 16));
                    cfg.res    = 12'($urandom_range(1, 6));
                end
                cfg.level = random_level();
                program_regs(cfg, 4'hF);
                lead_fs = 1'b1;
            end
            else if (kind < 85)
            begin
                // Level change in the middle of a frame.
                cfg.level = random_level();
                program_regs(cfg, 4'b1000);
            end
            else
            begin
                // Geometry change in the middle of a frame.
                cfg.width  = 12'($urandom_range(1, 20));
                cfg.height = 12'($urandom_range(1, 16));
                cfg.res    = 12'($urandom_range(1, 6));
                program_regs(cfg, 4'b0111);
            end
            if (n == 0)
            begin
                frame = clamp_dim(settings.width, MAX_W) * clamp_dim(settings.height, MAX_H);
                n     = frame + $urandom_range(0, frame);
                if (n > 200)
                    n = $urandom_range(60, 200);
            end
            for (int i = 0; i < n; i++)
                queue_random((i == 0) ? lead_fs : ($urandom_range(99) < 2));
            random_items += n;
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
